// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the pool tracker.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define SCPT_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion that is checked at every edge, reset included.
`define SCPT_ASSERT_ALW(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== src/scpt_pkg.sv =====
// Shared types, constants and size-class helpers of the pool tracker.
// No dependencies; used by the controller, the datapath and the checker.
package scpt_pkg;

  localparam int unsigned MIN_DIM       = 16;
  localparam int unsigned NUM_CLASSES   = 9;
  localparam int unsigned DIM_W         = 13;
  localparam int unsigned CLS_W         = 4;
  localparam int unsigned CNT_W         = 16;
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;
  localparam logic [CNT_W-1:0] PERIOD_RESET = 16'd10000;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_RANGE     = 2'd1,
    STS_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [CNT_W-1:0] in_use;
    logic [CNT_W-1:0] peak;
    logic [CNT_W-1:0] idle;
  } entry_t;

  typedef struct packed {
    logic             ok;
    logic [CLS_W-1:0] cls;
  } cls_res_t;

  typedef struct packed {
    logic accept;
    logic lookup;
    logic update;
    logic prune_rd;
    logic prune_wr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic prune_hit;
    logic prune_last;
    logic slot_free;
  } sts_t;

  // The class is the smallest c below num with d <= min_dim << c; a zero d or one above every class is not ok.
  function automatic cls_res_t dim_class(logic [DIM_W-1:0] d, int unsigned min_dim,
                                         int unsigned num);
    cls_res_t r;
    logic     found;
    r.ok  = 1'b0;
    r.cls = '0;
    found = 1'b0;
    for (int c = 0; c < (1 << CLS_W); c++) begin
      if (!found && (c < num) && (32'(d) <= (32'(min_dim) << c))) begin
        r.cls = CLS_W'(c);
        r.ok  = 1'b1;
        found = 1'b1;
      end
    end
    if (d == '0) begin
      r.ok = 1'b0;
    end
    if (!r.ok) begin
      r.cls = '0;
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] alloc_dim(logic [CLS_W-1:0] cls, int unsigned min_dim);
    return DIM_W'(32'(min_dim) << cls);
  endfunction

endpackage

// ===== src/size_class_pool_tracker.sv =====
// Top level of the size-class pool tracker: controller plus datapath.
// Depends on scpt_pkg, scpt_ctrl and scpt_dpath.
//
//   Channel  Handshake                Payload
//   in       in_valid_i / in_ready_o  req_type_i, width_i, height_i
//   out      out_valid_o/out_ready_i  class_x_o .. status_o
//   cfg      cfg_valid_i/cfg_ready_o  cfg_data_i (expiry period)
//
// An item passes through accept, table read (registered) and update; the next item
// is taken once the controller is back in idle. A release that starts a pruning
// pass adds a read and a write state per class entry and a done state to finish.
// After reset the table reads as zero at once through per-entry valid bits.
// A finished result waits in the output register; a new item is still accepted,
// and its update stalls until the register is free; a release that starts a
// pruning pass updates without waiting and its result waits in the done state.
module size_class_pool_tracker #(
  parameter int unsigned MinDim     = scpt_pkg::MIN_DIM,
  parameter int unsigned NumClasses = scpt_pkg::NUM_CLASSES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [scpt_pkg::DIM_W-1:0]      width_i,
  input  logic [scpt_pkg::DIM_W-1:0]      height_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [scpt_pkg::CLS_W-1:0]      class_x_o,
  output logic [scpt_pkg::CLS_W-1:0]      class_y_o,
  output logic [scpt_pkg::DIM_W-1:0]      alloc_width_o,
  output logic [scpt_pkg::DIM_W-1:0]      alloc_height_o,
  output logic                            reused_o,
  output logic                            pruned_o,
  output logic [scpt_pkg::CNT_W-1:0]      discarded_total_o,
  output logic [1:0]                      status_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [scpt_pkg::CNT_W-1:0]      cfg_data_i
);

  scpt_pkg::cmd_t cmd;
  scpt_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  scpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scpt_dpath #(
    .MinDim     (MinDim),
    .NumClasses (NumClasses)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_type_i        (req_type_i),
    .width_i           (width_i),
    .height_i          (height_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .class_x_o         (class_x_o),
    .class_y_o         (class_y_o),
    .alloc_width_o     (alloc_width_o),
    .alloc_height_o    (alloc_height_o),
    .reused_o          (reused_o),
    .pruned_o          (pruned_o),
    .discarded_total_o (discarded_total_o),
    .status_o          (status_o)
  );

endmodule

// ===== src/scpt_ctrl.sv =====
// Sequencing state machine of the pool tracker.
// Depends on scpt_pkg for the command and status structs.
module scpt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  scpt_pkg::sts_t  sts_i,
  output scpt_pkg::cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_LOOKUP   = 6'b000010,
    S_UPDATE   = 6'b000100,
    S_PRUNE_RD = 6'b001000,
    S_PRUNE_WR = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_UPDATE;
      end
      S_UPDATE: begin
        if (sts_i.prune_hit) begin
          cmd_o.update = 1'b1;
          state_d      = S_PRUNE_RD;
        end else if (sts_i.slot_free) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_PRUNE_RD: begin
        cmd_o.prune_rd = 1'b1;
        state_d        = S_PRUNE_WR;
      end
      S_PRUNE_WR: begin
        cmd_o.prune_wr = 1'b1;
        state_d        = sts_i.prune_last ? S_DONE : S_PRUNE_RD;
      end
      S_DONE: begin
        if (sts_i.slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== src/scpt_dpath.sv =====
// Datapath of the pool tracker: request register, class table, timer,
// pruning walk and result register. Depends on scpt_pkg.
module scpt_dpath #(
  parameter int unsigned MinDim     = scpt_pkg::MIN_DIM,
  parameter int unsigned NumClasses = scpt_pkg::NUM_CLASSES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  scpt_pkg::cmd_t                  cmd_i,
  output scpt_pkg::sts_t                  sts_o,
  input  logic                            req_type_i,
  input  logic [scpt_pkg::DIM_W-1:0]      width_i,
  input  logic [scpt_pkg::DIM_W-1:0]      height_i,
  input  logic                            cfg_valid_i,
  input  logic [scpt_pkg::CNT_W-1:0]      cfg_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [scpt_pkg::CLS_W-1:0]      class_x_o,
  output logic [scpt_pkg::CLS_W-1:0]      class_y_o,
  output logic [scpt_pkg::DIM_W-1:0]      alloc_width_o,
  output logic [scpt_pkg::DIM_W-1:0]      alloc_height_o,
  output logic                            reused_o,
  output logic                            pruned_o,
  output logic [scpt_pkg::CNT_W-1:0]      discarded_total_o,
  output logic [1:0]                      status_o
);

  localparam int unsigned Entries = NumClasses * NumClasses;
  localparam int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1;

  logic                          req_type_q;
  logic [scpt_pkg::DIM_W-1:0]    width_q, height_q;
  scpt_pkg::cls_res_t            cls_x, cls_y;
  logic                          cls_ok;
  logic [IdxW-1:0]               entry_idx;

  scpt_pkg::entry_t              mem_q [Entries];
  logic [Entries-1:0]            vld_q;
  scpt_pkg::entry_t              rd_data_q;
  logic                          rd_vld_q;
  scpt_pkg::entry_t              ent, upd_ent, prn_ent, wr_data;
  logic                          mem_we, mem_re;
  logic [IdxW-1:0]               wr_addr, rd_addr;

  logic [scpt_pkg::CNT_W-1:0]    timer_q, timer_d, timer_inc;
  logic [scpt_pkg::CNT_W-1:0]    period_q, period_d;
  logic [scpt_pkg::CNT_W-1:0]    acc_q, acc_d;
  logic [IdxW-1:0]               prune_idx_q, prune_idx_d;
  logic                          out_valid_q, out_valid_d;

  logic                          reused, peak_hit, rel_none, write_ok, prune_hit;
  logic [scpt_pkg::CNT_W-1:0]    limit, drop;
  logic [scpt_pkg::CNT_W:0]      acc_sum;
  logic                          out_load;
  scpt_pkg::status_e             status;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_type_q <= req_type_i;
      width_q    <= width_i;
      height_q   <= height_i;
    end
  end

  assign cls_x     = scpt_pkg::dim_class(width_q, MinDim, NumClasses);
  assign cls_y     = scpt_pkg::dim_class(height_q, MinDim, NumClasses);
  assign cls_ok    = cls_x.ok & cls_y.ok;
  assign entry_idx = IdxW'(32'(cls_x.cls) * NumClasses + 32'(cls_y.cls));

  assign ent = rd_vld_q ? rd_data_q : '0;

  always_comb begin
    upd_ent   = ent;
    reused    = 1'b0;
    peak_hit  = 1'b0;
    rel_none  = (ent.in_use == '0);
    timer_inc = (timer_q == scpt_pkg::CNT_MAX) ? timer_q : timer_q + 1'b1;
    if (!req_type_q) begin
      if (ent.idle != '0) begin
        upd_ent.idle = ent.idle - 1'b1;
        reused       = 1'b1;
      end
      if (ent.in_use != scpt_pkg::CNT_MAX) begin
        upd_ent.in_use = ent.in_use + 1'b1;
      end
      if (upd_ent.in_use > ent.peak) begin
        upd_ent.peak = upd_ent.in_use;
        peak_hit     = 1'b1;
      end
    end else begin
      if (ent.idle != scpt_pkg::CNT_MAX) begin
        upd_ent.idle = ent.idle + 1'b1;
      end
      upd_ent.in_use = ent.in_use - 1'b1;
    end
  end

  assign write_ok  = cls_ok & ~(req_type_q & rel_none);
  assign prune_hit = cls_ok & req_type_q & ~rel_none & (timer_inc >= period_q);

  always_comb begin
    limit          = (ent.peak >= ent.in_use) ? ent.peak - ent.in_use : '0;
    drop           = (ent.idle > limit) ? ent.idle - limit : '0;
    prn_ent.in_use = ent.in_use;
    prn_ent.peak   = ent.in_use;
    prn_ent.idle   = (ent.idle > limit) ? limit : ent.idle;
  end

  assign mem_we  = (cmd_i.update & write_ok) | cmd_i.prune_wr;
  assign wr_addr = cmd_i.prune_wr ? prune_idx_q : entry_idx;
  assign wr_data = cmd_i.prune_wr ? prn_ent : upd_ent;
  assign mem_re  = cmd_i.lookup | cmd_i.prune_rd;
  assign rd_addr = cmd_i.prune_rd ? prune_idx_q : entry_idx;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  assign acc_sum = {1'b0, acc_q} + {1'b0, drop};

  always_comb begin
    timer_d     = timer_q;
    period_d    = cfg_valid_i ? cfg_data_i : period_q;
    acc_d       = acc_q;
    prune_idx_d = prune_idx_q;
    if (cmd_i.update && cls_ok) begin
      if (!req_type_q) begin
        if (peak_hit) begin
          timer_d = '0;
        end
      end else if (!rel_none) begin
        timer_d = prune_hit ? '0 : timer_inc;
      end
    end
    if (cmd_i.update && prune_hit) begin
      acc_d       = '0;
      prune_idx_d = '0;
    end
    if (cmd_i.prune_wr) begin
      acc_d       = acc_sum[scpt_pkg::CNT_W] ? scpt_pkg::CNT_MAX
                                             : acc_sum[scpt_pkg::CNT_W-1:0];
      prune_idx_d = prune_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q     <= '0;
      period_q    <= scpt_pkg::PERIOD_RESET;
      acc_q       <= '0;
      prune_idx_q <= '0;
    end else begin
      timer_q     <= timer_d;
      period_q    <= period_d;
      acc_q       <= acc_d;
      prune_idx_q <= prune_idx_d;
    end
  end

  assign out_load    = (cmd_i.update & ~prune_hit) | cmd_i.finish;
  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  always_comb begin
    if (cmd_i.finish) begin
      status = scpt_pkg::STS_OK;
    end else if (!cls_ok) begin
      status = scpt_pkg::STS_RANGE;
    end else if (req_type_q && rel_none) begin
      status = scpt_pkg::STS_UNDERFLOW;
    end else begin
      status = scpt_pkg::STS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      class_x_o         <= cls_ok ? cls_x.cls : '0;
      class_y_o         <= cls_ok ? cls_y.cls : '0;
      alloc_width_o     <= cls_ok ? scpt_pkg::alloc_dim(cls_x.cls, MinDim) : '0;
      alloc_height_o    <= cls_ok ? scpt_pkg::alloc_dim(cls_y.cls, MinDim) : '0;
      reused_o          <= cmd_i.update & cls_ok & reused;
      pruned_o          <= cmd_i.finish;
      discarded_total_o <= cmd_i.finish ? acc_q : '0;
      status_o          <= status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sts_o.prune_hit  = prune_hit;
  assign sts_o.prune_last = (prune_idx_q == IdxW'(Entries - 1));
  assign sts_o.slot_free  = ~out_valid_q | out_ready_i;

endmodule

// ===== src/scpt_checker.sv =====
// Port-level assertions for the pool tracker, bound to the top level.
// Depends on scpt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scpt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [scpt_pkg::CLS_W-1:0]      class_x_o,
  input logic [scpt_pkg::DIM_W-1:0]      alloc_width_o,
  input logic                            reused_o,
  input logic                            pruned_o,
  input logic [scpt_pkg::CNT_W-1:0]      discarded_total_o,
  input logic [1:0]                      status_o
);

  // Only one request is worked on at a time.
  `SCPT_ASSERT_RST(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "request accepted while another is in flight")

  `SCPT_ASSERT_RST(a_range_clears, clk_i, rst_ni, out_valid_o && status_o == scpt_pkg::STS_RANGE |-> class_x_o == '0 && alloc_width_o == '0 && !reused_o && !pruned_o, "out-of-range result carries data")

  `SCPT_ASSERT_RST(a_discard_only_pruned, clk_i, rst_ni, out_valid_o && !pruned_o |-> discarded_total_o == '0, "discard count without a pruning pass")

  `SCPT_ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(class_x_o), "stalled result changed")

  `SCPT_ASSERT_ALW(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o, "result shown during reset")

endmodule

bind size_class_pool_tracker scpt_checker u_scpt_checker (.*);

// ===== tb/pool_ledger_pkg.sv =====
// Result types and the expected-result ledger of the pool tracker testbench.
// Depends on scpt_pkg for the size-class constants and the status codes.
package pool_ledger_pkg;

  localparam int unsigned ENTRIES = scpt_pkg::NUM_CLASSES * scpt_pkg::NUM_CLASSES;
  localparam int unsigned MAX_REPORTS = 100;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic [scpt_pkg::CLS_W-1:0] class_x;
    logic [scpt_pkg::CLS_W-1:0] class_y;
    logic [scpt_pkg::DIM_W-1:0] alloc_width;
    logic [scpt_pkg::DIM_W-1:0] alloc_height;
    logic                       reused;
    logic                       pruned;
    logic [scpt_pkg::CNT_W-1:0] discarded;
    scpt_pkg::status_e          status;
  } pool_result_t;

  class pool_ledger;
    logic [scpt_pkg::CNT_W-1:0] in_use [ENTRIES];
    logic [scpt_pkg::CNT_W-1:0] peak [ENTRIES];
    logic [scpt_pkg::CNT_W-1:0] idle [ENTRIES];
    logic [scpt_pkg::CNT_W-1:0] timer;
    logic [scpt_pkg::CNT_W-1:0] period;
    pool_result_t               pending_results[$];
    int unsigned                errors;

    function new();
      foreach (in_use[i]) begin
        in_use[i] = '0;
        peak[i]   = '0;
        idle[i]   = '0;
      end
      timer  = '0;
      period = scpt_pkg::PERIOD_RESET;
      errors = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Returns the size class of a dimension, or -1 when it has none.
    function int class_of(logic [scpt_pkg::DIM_W-1:0] d);
      int unsigned q;
      int          c;
      if (d == '0) begin
        return -1;
      end
      if (32'(d) <= scpt_pkg::MIN_DIM) begin
        return 0;
      end
      q = (32'(d) - 1) / scpt_pkg::MIN_DIM;
      c = 1;
      while (q > 1) begin
        q = q >> 1;
        c++;
      end
      return (c >= int'(scpt_pkg::NUM_CLASSES)) ? -1 : c;
    endfunction

    function logic [scpt_pkg::CNT_W-1:0] prune_all_classes();
      int unsigned dropped;
      int unsigned limit;
      dropped = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        limit = (peak[i] >= in_use[i]) ? 32'(peak[i]) - 32'(in_use[i]) : 0;
        if (32'(idle[i]) > limit) begin
          dropped += 32'(idle[i]) - limit;
          idle[i] = scpt_pkg::CNT_W'(limit);
        end
        peak[i] = in_use[i];
      end
      return (dropped > 32'(scpt_pkg::CNT_MAX)) ? scpt_pkg::CNT_MAX
                                                 : scpt_pkg::CNT_W'(dropped);
    endfunction

    // Applies one accepted request to the pool and queues the result it must produce.
    function void take_request(logic op, logic [scpt_pkg::DIM_W-1:0] w,
                               logic [scpt_pkg::DIM_W-1:0] h);
      pool_result_t r;
      int           cx;
      int           cy;
      int           e;
      r  = '0;
      cx = class_of(w);
      cy = class_of(h);
      if (cx < 0 || cy < 0) begin
        r.status = scpt_pkg::STS_RANGE;
        pending_results.push_back(r);
        return;
      end
      e              = cx * scpt_pkg::NUM_CLASSES + cy;
      r.class_x      = scpt_pkg::CLS_W'(cx);
      r.class_y      = scpt_pkg::CLS_W'(cy);
      r.alloc_width  = scpt_pkg::DIM_W'(scpt_pkg::MIN_DIM << cx);
      r.alloc_height = scpt_pkg::DIM_W'(scpt_pkg::MIN_DIM << cy);
      r.status       = scpt_pkg::STS_OK;
      if (op == OP_ACQUIRE) begin
        if (idle[e] != '0) begin
          idle[e]  = idle[e] - 1'b1;
          r.reused = 1'b1;
        end
        if (in_use[e] != scpt_pkg::CNT_MAX) begin
          in_use[e] = in_use[e] + 1'b1;
        end
        if (in_use[e] > peak[e]) begin
          peak[e] = in_use[e];
          timer   = '0;
        end
      end else if (in_use[e] == '0) begin
        r.status = scpt_pkg::STS_UNDERFLOW;
      end else begin
        if (idle[e] != scpt_pkg::CNT_MAX) begin
          idle[e] = idle[e] + 1'b1;
        end
        in_use[e] = in_use[e] - 1'b1;
        if (timer != scpt_pkg::CNT_MAX) begin
          timer = timer + 1'b1;
        end
        if (timer >= period) begin
          timer       = '0;
          r.discarded = prune_all_classes();
          r.pruned    = 1'b1;
        end
      end
      pending_results.push_back(r);
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        if (errors < MAX_REPORTS) begin
          $error("%s: expected %0d, got %0d", name, want, got);
        end
        errors++;
      end
    endfunction

    function void check_result(pool_result_t got);
      pool_result_t want;
      if (pending_results.size() == 0) begin
        if (errors < MAX_REPORTS) begin
          $error("result arrived with no request outstanding");
        end
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare("class_x", want.class_x, got.class_x);
      compare("class_y", want.class_y, got.class_y);
      compare("alloc_width", want.alloc_width, got.alloc_width);
      compare("alloc_height", want.alloc_height, got.alloc_height);
      compare("reused", want.reused, got.reused);
      compare("pruned", want.pruned, got.pruned);
      compare("discarded_total", want.discarded, got.discarded);
      compare("status", want.status, got.status);
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench of the size-class pool tracker: clock, reset, request
// driver, result monitor and phase sequencing. Depends on scpt_pkg,
// pool_ledger_pkg and size_class_pool_tracker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic                         req_type_i = 1'b0;
  logic [scpt_pkg::DIM_W-1:0]   width_i = '0;
  logic [scpt_pkg::DIM_W-1:0]   height_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [scpt_pkg::CLS_W-1:0]   class_x_o;
  logic [scpt_pkg::CLS_W-1:0]   class_y_o;
  logic [scpt_pkg::DIM_W-1:0]   alloc_width_o;
  logic [scpt_pkg::DIM_W-1:0]   alloc_height_o;
  logic                         reused_o;
  logic                         pruned_o;
  logic [scpt_pkg::CNT_W-1:0]   discarded_total_o;
  logic [1:0]                   status_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [scpt_pkg::CNT_W-1:0]   cfg_data_i = '0;

  pool_ledger_pkg::pool_ledger  ledger;
  int unsigned                  tx_gap_pct = 0;
  int unsigned                  rx_stall_pct = 0;
  int unsigned                  pressure_req = 0;
  int unsigned                  pressure_seen = 0;
  int unsigned                  hold_left = 0;
  logic [2*scpt_pkg::DIM_W-1:0] live_bufs[$];

  size_class_pool_tracker dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .width_i           (width_i),
    .height_i          (height_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .class_x_o         (class_x_o),
    .class_y_o         (class_y_o),
    .alloc_width_o     (alloc_width_o),
    .alloc_height_o    (alloc_height_o),
    .reused_o          (reused_o),
    .pruned_o          (pruned_o),
    .discarded_total_o (discarded_total_o),
    .status_o          (status_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver stalls at random, and for a long stretch whenever pressure is asked for.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (pressure_seen != pressure_req) begin
      pressure_seen <= pressure_req;
      hold_left     <= 300;
      out_ready_i   <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    pool_ledger_pkg::pool_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.class_x      = class_x_o;
      got.class_y      = class_y_o;
      got.alloc_width  = alloc_width_o;
      got.alloc_height = alloc_height_o;
      got.reused       = reused_o;
      got.pruned       = pruned_o;
      got.discarded    = discarded_total_o;
      got.status       = scpt_pkg::status_e'(status_o);
      ledger.check_result(got);
    end
  end

  task automatic send_item(input logic op, input logic [scpt_pkg::DIM_W-1:0] w,
                           input logic [scpt_pkg::DIM_W-1:0] h);
    int unsigned gap;
    gap = 0;
    if (tx_gap_pct != 0) begin
      while ($urandom_range(99) < tx_gap_pct) begin
        gap++;
      end
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= op;
    width_i    <= w;
    height_i   <= h;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.take_request(op, w, h);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_period(input logic [scpt_pkg::CNT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    ledger.period = value;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin
        tx_gap_pct = 0;
        rx_stall_pct <= 0;
      end
      1: begin
        tx_gap_pct = 56;
        rx_stall_pct <= 0;
      end
      2: begin
        tx_gap_pct = 0;
        rx_stall_pct <= 56;
      end
      default: begin
        tx_gap_pct = 31;
        rx_stall_pct <= 31;
      end
    endcase
  endtask

  function automatic int unsigned pick_class();
    return ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(8);
  endfunction

  function automatic logic [scpt_pkg::DIM_W-1:0] dim_in_class(int unsigned c);
    if (c == 0) begin
      return scpt_pkg::DIM_W'($urandom_range(scpt_pkg::MIN_DIM, 1));
    end
    return scpt_pkg::DIM_W'($urandom_range(scpt_pkg::MIN_DIM << c,
                                           (scpt_pkg::MIN_DIM << (c - 1)) + 1));
  endfunction

  // Mostly acquires and releases of live buffers; the rest are untracked requests of either kind, some with bad sizes.
  task automatic send_random();
    int unsigned                pick;
    int unsigned                idx;
    logic                       op;
    logic [scpt_pkg::DIM_W-1:0] w;
    logic [scpt_pkg::DIM_W-1:0] h;
    pick = $urandom_range(99);
    if (live_bufs.size() > 48) begin
      pick = 60;
    end
    if (pick >= 50 && pick < 85 && live_bufs.size() != 0) begin
      idx    = $urandom_range(live_bufs.size() - 1);
      op     = pool_ledger_pkg::OP_RELEASE;
      {w, h} = live_bufs[idx];
      live_bufs.delete(idx);
    end else if (pick < 85) begin
      op = pool_ledger_pkg::OP_ACQUIRE;
      w  = dim_in_class(pick_class());
      h  = dim_in_class(pick_class());
      live_bufs.push_back({w, h});
    end else if (pick < 90) begin
      op = 1'($urandom_range(1));
      w  = dim_in_class(pick_class());
      h  = dim_in_class(pick_class());
    end else begin
      op = 1'($urandom_range(1));
      w  = scpt_pkg::DIM_W'($urandom_range(8191));
      h  = scpt_pkg::DIM_W'($urandom_range(8191));
      case ($urandom_range(2))
        0: w = '0;
        1: w = scpt_pkg::DIM_W'($urandom_range(8191, 4097));
        default: h = ($urandom_range(1) == 0) ? '0
                                              : scpt_pkg::DIM_W'($urandom_range(8191, 4097));
      endcase
    end
    send_item(op, w, h);
  endtask

  initial begin : watchdog
    #50ms;
    $display("** size_class_pool_tracker: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [scpt_pkg::CNT_W-1:0] periods[5];
    ledger = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(pool_ledger_pkg::OP_ACQUIRE, 13'd1, 13'd1);
    send_item(pool_ledger_pkg::OP_ACQUIRE, 13'd16, 13'd16);
    send_item(pool_ledger_pkg::OP_ACQUIRE, 13'd17, 13'd4096);
    send_item(pool_ledger_pkg::OP_ACQUIRE, 13'd4096, 13'd17);
    send_item(pool_ledger_pkg::OP_ACQUIRE, 13'd0, 13'd20);
    send_item(pool_ledger_pkg::OP_ACQUIRE, 13'd8, 13'd0);
    send_item(pool_ledger_pkg::OP_ACQUIRE, 13'd4097, 13'd16);
    send_item(pool_ledger_pkg::OP_ACQUIRE, 13'd16, 13'd8191);
    send_item(pool_ledger_pkg::OP_ACQUIRE, 13'd8191, 13'd8191);
    send_item(pool_ledger_pkg::OP_RELEASE, 13'd4096, 13'd4096);
    send_item(pool_ledger_pkg::OP_RELEASE, 13'd1, 13'd1);
    send_item(pool_ledger_pkg::OP_ACQUIRE, 13'd5, 13'd9);
    send_item(pool_ledger_pkg::OP_RELEASE, 13'd0, 13'd100);
    send_item(pool_ledger_pkg::OP_RELEASE, 13'd17, 13'd4096);
    send_item(pool_ledger_pkg::OP_ACQUIRE, 13'd33, 13'd65);
    send_item(pool_ledger_pkg::OP_ACQUIRE, 13'd129, 13'd257);
    send_item(pool_ledger_pkg::OP_ACQUIRE, 13'd513, 13'd1025);
    send_item(pool_ledger_pkg::OP_ACQUIRE, 13'd2049, 13'd2048);
    send_item(pool_ledger_pkg::OP_RELEASE, 13'd4096, 13'd17);
    send_item(pool_ledger_pkg::OP_RELEASE, 13'd4096, 13'd17);
    drain();

    periods = '{16'd1, 16'hFFFF, 16'($urandom_range(12, 2)), 16'd0,
                16'($urandom_range(60, 13))};
    for (int p = 0; p < 5; p++) begin
      write_period(periods[p]);
      for (int m = 0; m < 4; m++) begin
        set_idling(m);
        if (p == 0 && m == 0) begin
          pressure_req <= pressure_req + 1;
        end
        repeat (75) send_random();
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("** size_class_pool_tracker: PASSED **");
    end else begin
      $display("** size_class_pool_tracker: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/scpt_pkg.sv
src/scpt_ctrl.sv
src/scpt_dpath.sv
src/size_class_pool_tracker.sv
src/scpt_checker.sv
tb/pool_ledger_pkg.sv
tb/tb.sv
